// ===== src/assert_macros.svh =====
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms used by the RTL. Defining ASSERT_OFF
// removes every check.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("invariant check failed");

`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)

`define ASSERT_IMPL(label, clk, rst, ante, cons)

`endif

`endif

// ===== src/slds_pkg.sv =====
// ============================================================================
// slds_pkg
// Types, codes and the control store of the sorted list doubling search.
// ============================================================================
package slds_pkg;

   localparam int DEPTH_DEFAULT = 1024;
   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

   localparam logic [1:0] KIND_CLEAR  = 2'd0;
   localparam logic [1:0] KIND_APPEND = 2'd1;
   localparam logic [1:0] KIND_QUERY  = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] item_value;
   } req_type;

   typedef struct packed {
      logic       found;
      logic [9:0] position;
   } rsp_type;

   typedef logic [2:0] step_type;

   localparam step_type ST_IDLE  = 3'd0;
   localparam step_type ST_DADDR = 3'd1;
   localparam step_type ST_DCMP  = 3'd2;
   localparam step_type ST_BADDR = 3'd3;
   localparam step_type ST_BCMP  = 3'd4;
   localparam step_type ST_DONE  = 3'd5;

   typedef struct packed {
      logic     wait_req;
      logic     rd_en;
      logic     mid_sel;
      logic     cmp_en;
      logic     dbl;
      logic     emit;
      step_type nxt;
      step_type jmp_eq;
      step_type jmp_gt;
   } ctl_word_type;

   function automatic ctl_word_type ucode(input step_type step);
      ctl_word_type cw;
      cw = '0;
      cw.nxt    = ST_IDLE;
      cw.jmp_eq = ST_IDLE;
      cw.jmp_gt = ST_IDLE;
      case (step)
         ST_IDLE: begin
            cw.wait_req = 1'b1;
         end
         ST_DADDR: begin
            cw.rd_en = 1'b1;
            cw.nxt   = ST_DCMP;
         end
         ST_DCMP: begin
            cw.cmp_en = 1'b1;
            cw.dbl    = 1'b1;
            cw.nxt    = ST_DADDR;
            cw.jmp_eq = ST_DONE;
            cw.jmp_gt = ST_BADDR;
         end
         ST_BADDR: begin
            cw.rd_en   = 1'b1;
            cw.mid_sel = 1'b1;
            cw.nxt     = ST_BCMP;
         end
         ST_BCMP: begin
            cw.cmp_en = 1'b1;
            cw.nxt    = ST_BADDR;
            cw.jmp_eq = ST_DONE;
            cw.jmp_gt = ST_BADDR;
         end
         ST_DONE: begin
            cw.emit = 1'b1;
         end
         default: begin
            cw.nxt = ST_IDLE;
         end
      endcase
      return cw;
   endfunction

endpackage

// ===== src/sorted_list_doubling_search.sv =====
// ============================================================================
// sorted_list_doubling_search
// Ascending list of 32-bit values with a doubling-then-binary search,
// run by a small microcoded sequencer over a list memory with one write port and one read port.
//
//   channel  ports                         carries
//   request  req_valid req_ready req_data  clear, append or query
//   response rsp_valid rsp_ready rsp_data  found flag and position
//
// Clear and append may follow back to back.
// A query runs list probes, doubling and then binary, and ends in the
// DONE step; each probe is a memory read step followed by a compare step.
// Reset empties the list; no clearing pass is needed.
// A finished response waits in its output register while new requests
// are taken; a later query holds in its final step until that slot frees.
// ============================================================================
`include "assert_macros.svh"

module sorted_list_doubling_search #(
   parameter int DEPTH = slds_pkg::DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  slds_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output slds_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = AW + 1;
   localparam int IW = AW + 2;

   slds_pkg::step_type     step_ff, step_in;
   slds_pkg::ctl_word_type cw;
   logic [CW-1:0]          count_ff, count_in;
   logic [31:0]            value_ff, value_in;
   logic [IW-1:0]          ind_ff, ind_in;
   logic [IW-1:0]          p_ff, p_in;
   logic [IW-1:0]          q_ff, q_in;
   logic [PW-1:0]          addr_ff, addr_in;
   logic                   past_ff, past_in;
   logic                   last_ff, last_in;
   logic                   hit_ff, hit_in;
   logic [PW-1:0]          where_ff, where_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   slds_pkg::rsp_type      rsp_data_ff, rsp_data_in;

   logic                   mem_we;
   logic                   mem_re;
   logic [31:0]            rd_data;
   logic [PW-1:0]          probe_addr;
   logic [IW:0]            pq_sum;
   logic                   pq_adjacent;
   logic                   eq;
   logic                   gt;
   logic [PW+9:0]          where_ext;

   slds_mem #(
      .DEPTH(DEPTH),
      .AW   (AW)
   ) u_mem (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(count_ff[AW-1:0]),
      .wr_data(req_data.item_value),
      .rd_en  (mem_re),
      .rd_addr(probe_addr[AW-1:0]),
      .rd_data(rd_data)
   );

   assign cw          = slds_pkg::ucode(step_ff);
   assign req_ready   = cw.wait_req;
   assign pq_sum      = {1'b0, p_ff} + {1'b0, q_ff};
   assign pq_adjacent = (p_ff + IW'(1)) == q_ff;
   assign probe_addr  = !cw.mid_sel ? PW'(ind_ff - IW'(1)) :
                        pq_adjacent ? PW'(p_ff) : PW'(pq_sum[IW:1]);
   assign eq          = !past_ff && (rd_data == value_ff);
   assign gt          = past_ff || (rd_data > value_ff);
   assign where_ext   = {10'b0, where_ff};

   always_comb begin
      step_in      = step_ff;
      count_in     = count_ff;
      value_in     = value_ff;
      ind_in       = ind_ff;
      p_in         = p_ff;
      q_in         = q_ff;
      addr_in      = addr_ff;
      past_in      = past_ff;
      last_in      = last_ff;
      hit_in       = hit_ff;
      where_in     = where_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (cw.wait_req && req_valid) begin
         case (req_data.kind)
            slds_pkg::KIND_CLEAR: begin
               count_in = '0;
            end
            slds_pkg::KIND_APPEND: begin
               if (req_data.item_value != slds_pkg::ALL_ONES &&
                   count_ff < CW'(DEPTH)) begin
                  mem_we   = 1'b1;
                  count_in = count_ff + CW'(1);
               end
            end
            slds_pkg::KIND_QUERY: begin
               value_in = req_data.item_value;
               ind_in   = IW'(1);
               hit_in   = 1'b0;
               last_in  = 1'b0;
               where_in = '0;
               step_in  = slds_pkg::ST_DADDR;
            end
            default: begin
               step_in = step_ff;
            end
         endcase
      end

      if (cw.rd_en) begin
         mem_re  = 1'b1;
         addr_in = probe_addr;
         past_in = probe_addr >= PW'(count_ff);
         last_in = cw.mid_sel && pq_adjacent;
         step_in = cw.nxt;
      end

      if (cw.cmp_en) begin
         if (eq) begin
            hit_in   = 1'b1;
            where_in = addr_ff;
            step_in  = cw.jmp_eq;
         end else if (last_ff) begin
            step_in = cw.jmp_eq;
         end else if (cw.dbl) begin
            if (gt) begin
               p_in    = '0;
               q_in    = ind_ff;
               step_in = cw.jmp_gt;
            end else begin
               ind_in  = ind_ff << 1;
               step_in = cw.nxt;
            end
         end else begin
            if (gt) begin
               q_in    = IW'(addr_ff);
               step_in = cw.jmp_gt;
            end else begin
               p_in    = IW'(addr_ff);
               step_in = cw.nxt;
            end
         end
      end

      if (cw.emit && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.found    = hit_ff;
         rsp_data_in.position = where_ext[9:0];
         step_in              = cw.nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= slds_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      ind_ff      <= ind_in;
      p_ff        <= p_in;
      q_ff        <= q_in;
      addr_ff     <= addr_in;
      past_ff     <= past_in;
      last_ff     <= last_in;
      hit_ff      <= hit_in;
      where_ff    <= where_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CW'(DEPTH))
   `ASSERT_IMPL(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(step_ff == slds_pkg::ST_DONE))
   `ASSERT_IMPL(a_bin_order, clock, reset, step_ff == slds_pkg::ST_BCMP, p_ff < q_ff)
   `ASSERT_IMPL(a_hit_in_list, clock, reset, step_ff == slds_pkg::ST_DONE && hit_ff, where_ff < PW'(count_ff))

endmodule

// ===== src/slds_mem.sv =====
// ============================================================================
// slds_mem
// List storage with one write port, one read port and a registered read.
// ============================================================================
module slds_mem #(
   parameter int DEPTH = slds_pkg::DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [31:0]   rd_data
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
